>>> hdl/u8sd_pkg.sv
// Shared constants and helper functions for the UTF-8 stream decoder.
// No dependencies; imported by utf8_stream_decoder_unit, utf8_decode_monitor and the test.
`timescale 1ns / 1ps
`default_nettype none

package u8sd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CpW    = 31;
  localparam int unsigned LenW   = 3;
  localparam int unsigned OutW   = 40;  // code_point + sequence_length, padded to bytes

  localparam logic [CpW-1:0]  QmarkCp = CpW'(8'h3F);
  localparam logic [LenW-1:0] LenOne  = 3'd1;

  // Sequence length implied by a lead byte; continuation and 0xFE/0xFF give 1
  function automatic logic [LenW-1:0] lead_len(input logic [ByteW-1:0] b);
    logic [LenW-1:0] len;
    if (!b[7]) begin
      len = 3'd1;
    end else if (!b[6]) begin
      len = 3'd1;
    end else if (!b[5]) begin
      len = 3'd2;
    end else if (!b[4]) begin
      len = 3'd3;
    end else if (!b[3]) begin
      len = 3'd4;
    end else if (!b[2]) begin
      len = 3'd5;
    end else if (!b[1]) begin
      len = 3'd6;
    end else begin
      len = 3'd1;
    end
    return len;
  endfunction

  // Payload bits carried by a lead byte of the given length
  function automatic logic [6:0] lead_mask(input logic [LenW-1:0] len);
    logic [6:0] m;
    case (len)
      3'd2:    m = 7'h1F;
      3'd3:    m = 7'h0F;
      3'd4:    m = 7'h07;
      3'd5:    m = 7'h03;
      3'd6:    m = 7'h01;
      default: m = 7'h7F;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

>>> hdl/utf8_stream_decoder_unit.sv
// UTF-8 stream decoder: one byte per transaction in, one code point per
// completed or truncated sequence out. Depends on u8sd_pkg.
// A result is registered into the output register on the edge that accepts the
// byte ending its sequence. Throughput: one byte per cycle; input stalls only
// while a result is held by a low m_tready.
// Reset (rst, synchronous, active high) clears the sequence state and m_tvalid.
`timescale 1ns / 1ps
`default_nettype none

module utf8_stream_decoder_unit
  import u8sd_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  // Input stream
  input  wire logic            s_tvalid,
  output logic                 s_tready,
  input  wire logic [7:0]      s_tdata,   // [7:0] data_byte
  input  wire logic            s_tlast,   // end_of_buffer
  // Result stream
  output logic                 m_tvalid,
  input  wire logic            m_tready,
  output logic [OutW-1:0]      m_tdata,   // [30:0] code_point, [33:31] sequence_length
  output logic                 m_tuser    // [0] truncated
);

  // Sequence state
  logic [LenW-1:0] bytes_remaining, bytes_remaining_next;
  logic [CpW-1:0]  partial_value, partial_value_next;
  logic [LenW-1:0] lead_length, lead_length_next;

  // Result of the current byte
  logic            res_valid;
  logic [CpW-1:0]  res_cp;
  logic            res_trunc;
  logic [LenW-1:0] res_len;

  logic            in_xact;
  logic [LenW-1:0] len_in;
  logic [CpW-1:0]  shifted;
  logic [LenW-1:0] rem_dec;

  // Accept while the output register is empty or being drained
  assign s_tready = !m_tvalid || m_tready;
  assign in_xact  = s_tvalid && s_tready;

  assign len_in  = lead_len(s_tdata);
  assign shifted = {partial_value[CpW-7:0], s_tdata[5:0]};
  assign rem_dec = bytes_remaining - LenW'(1);

  // Decode step
  always_comb begin
    bytes_remaining_next = bytes_remaining;
    partial_value_next   = partial_value;
    lead_length_next     = lead_length;
    res_valid            = 1'b0;
    res_cp               = '0;
    res_trunc            = 1'b0;
    res_len              = LenOne;
    if (bytes_remaining == '0) begin
      if (len_in == LenOne) begin
        res_valid = 1'b1;
        res_cp    = CpW'(s_tdata[6:0]);
      end else if (s_tlast) begin
        // buffer ends right on a multi-byte lead
        res_valid            = 1'b1;
        res_cp               = QmarkCp;
        res_trunc            = 1'b1;
        res_len              = len_in;
        bytes_remaining_next = '0;
        partial_value_next   = '0;
        lead_length_next     = '0;
      end else begin
        partial_value_next   = CpW'(s_tdata[6:0] & lead_mask(len_in));
        bytes_remaining_next = len_in - LenW'(1);
        lead_length_next     = len_in;
      end
    end else if (rem_dec == '0) begin
      // sequence complete
      res_valid            = 1'b1;
      res_cp               = shifted;
      res_len              = lead_length;
      bytes_remaining_next = '0;
      partial_value_next   = '0;
      lead_length_next     = '0;
    end else if (s_tlast) begin
      // buffer ends mid-sequence
      res_valid            = 1'b1;
      res_cp               = QmarkCp;
      res_trunc            = 1'b1;
      res_len              = lead_length;
      bytes_remaining_next = '0;
      partial_value_next   = '0;
      lead_length_next     = '0;
    end else begin
      partial_value_next   = shifted;
      bytes_remaining_next = rem_dec;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_remaining <= '0;
      partial_value   <= '0;
      lead_length     <= '0;
    end else if (in_xact) begin
      bytes_remaining <= bytes_remaining_next;
      partial_value   <= partial_value_next;
      lead_length     <= lead_length_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_xact && res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xact && res_valid) begin
      m_tdata <= {(OutW-CpW-LenW)'(0), res_len, res_cp};
      m_tuser <= res_trunc;
    end
  end

endmodule

`default_nettype wire

>>> tb/utf8_decode_monitor.sv
// Passive monitor for the UTF-8 stream decoder: predicts each code point from the
// accepted input bytes and compares it with the result stream.
// Depends on u8sd_pkg for the result bus width.
`timescale 1ns / 1ps

module utf8_decode_monitor
  import u8sd_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  input  logic            s_tready,
  input  logic [7:0]      s_tdata,    // [7:0] data_byte
  input  logic            s_tlast,    // end_of_buffer
  input  logic            m_tvalid,
  input  logic            m_tready,
  input  logic [OutW-1:0] m_tdata,    // [30:0] code_point, [33:31] sequence_length
  input  logic            m_tuser,    // [0] truncated
  output int              fail_count,
  output int              pending
);

  localparam logic [30:0] QUESTION_MARK = 31'h3F;

  typedef struct packed {
    logic [30:0] code_point;
    logic        truncated;
    logic [2:0]  seq_len;
  } char_result_t;

  // Decoder state as the monitor sees it
  logic [2:0]  bytes_left;
  logic [30:0] accum;
  logic [2:0]  open_len;

  char_result_t expected_chars [$];
  char_result_t want;
  char_result_t got;

  // Length announced by a lead byte; stray continuations and 0xFE/0xFF stand alone
  function automatic logic [2:0] length_of_lead(input logic [7:0] b);
    casez (b)
      8'b110?????: return 3'd2;
      8'b1110????: return 3'd3;
      8'b11110???: return 3'd4;
      8'b111110??: return 3'd5;
      8'b1111110?: return 3'd6;
      default:     return 3'd1;
    endcase
  endfunction

  // Advance the decoder by one byte; returns 1 when a character comes out
  function automatic bit decode_byte(input logic [7:0] b, input logic eob,
                                     output char_result_t r);
    logic [2:0] len;
    logic [7:0] lead_bits;
    r = '0;
    if (bytes_left == 3'd0) begin
      len = length_of_lead(b);
      if (len == 3'd1) begin
        r.code_point = {24'd0, b[6:0]};
        r.seq_len    = 3'd1;
        return 1'b1;
      end
      if (eob) begin
        r.code_point = QUESTION_MARK;
        r.truncated  = 1'b1;
        r.seq_len    = len;
        return 1'b1;
      end
      lead_bits  = b & (8'h7F >> len);
      accum      = {23'd0, lead_bits};
      bytes_left = len - 3'd1;
      open_len   = len;
      return 1'b0;
    end
    // any byte after a multi-byte lead is payload, continuation or not
    accum      = {accum[24:0], b[5:0]};
    bytes_left = bytes_left - 3'd1;
    if (bytes_left == 3'd0) begin
      r.code_point = accum;
      r.seq_len    = open_len;
    end else if (eob) begin
      r.code_point = QUESTION_MARK;
      r.truncated  = 1'b1;
      r.seq_len    = open_len;
      bytes_left   = 3'd0;
    end else begin
      return 1'b0;
    end
    accum    = '0;
    open_len = '0;
    return 1'b1;
  endfunction

  // Outputs are scored before the new input is predicted; a byte's result
  // cannot leave the block on the edge that accepts it
  always @(posedge clk) begin
    if (rst) begin
      bytes_left = '0;
      accum      = '0;
      open_len   = '0;
      fail_count = 0;
      expected_chars.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.code_point = m_tdata[30:0];
        got.seq_len    = m_tdata[33:31];
        got.truncated  = m_tuser;
        if (expected_chars.size() == 0) begin
          $error("unexpected result: code_point %h truncated %0d sequence_length %0d",
                 got.code_point, got.truncated, got.seq_len);
          fail_count++;
        end else begin
          want = expected_chars.pop_front();
          if (got.code_point !== want.code_point) begin
            $error("code_point: expected %h, actual %h", want.code_point, got.code_point);
            fail_count++;
          end
          if (got.truncated !== want.truncated) begin
            $error("truncated: expected %0d, actual %0d", want.truncated, got.truncated);
            fail_count++;
          end
          if (got.seq_len !== want.seq_len) begin
            $error("sequence_length: expected %0d, actual %0d", want.seq_len, got.seq_len);
            fail_count++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        if (decode_byte(s_tdata, s_tlast, want)) begin
          expected_chars.insert(expected_chars.size(), want);
        end
      end
    end
    pending = expected_chars.size();
  end

endmodule

>>> tb/utf8_stream_decoder_unit_test.sv
// Top of the UTF-8 stream decoder regression: clock, reset, byte stimulus with
// bursty valid and stalling ready, and the final verdict.
// Depends on u8sd_pkg, utf8_stream_decoder_unit and utf8_decode_monitor.
`timescale 1ns / 1ps

module utf8_stream_decoder_unit_test;
  import u8sd_pkg::*;

  localparam int BYTE_TARGET = 1950;

  logic            clk;
  logic            rst;
  logic            s_tvalid;
  logic            s_tready;
  logic [7:0]      s_tdata;   // [7:0] data_byte
  logic            s_tlast;   // end_of_buffer
  logic            m_tvalid;
  logic            m_tready;
  logic [OutW-1:0] m_tdata;   // [30:0] code_point, [33:31] sequence_length
  logic            m_tuser;   // [0] truncated

  int fail_count;
  int pending;
  int bytes_sent;
  int burst_left;
  bit hold_req;

  // {end_of_buffer, data_byte}: single bytes, each sequence length, truncation
  logic [8:0] opening_bytes [$] = '{
    9'h000, 9'h07F, 9'h080, 9'h0FE, 9'h0FF,            // standalone bytes
    9'h0FD, 9'h0BF, 9'h0BF, 9'h0BF, 9'h0BF, 9'h0BF,    // 6 bytes, largest value
    9'h0F0, 9'h09F, 9'h098, 9'h080,                    // 4 bytes
    9'h0E2, 9'h041, 9'h0AC,                            // 3 bytes, ASCII as payload
    9'h0C3, 9'h1A9,                                    // buffer ends on last byte
    9'h1C3,                                            // buffer ends on a lead
    9'h0F8, 9'h088, 9'h180                             // buffer ends mid 5-byte run
  };

  utf8_stream_decoder_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  utf8_decode_monitor i_monitor (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Offer one byte; enters and leaves on a falling edge
  task automatic send_byte(input logic [7:0] b, input logic eob);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 32);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= eob;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    bytes_sent++;
  endtask

  // Stop offering until every predicted character has been seen
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // Receiver: ready runs broken by short stalls, plus one long hold-off
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    m_tready  = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        m_tready <= 1'b0;
        repeat (300) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(negedge clk);
        if ($urandom_range(0, 7) != 0) begin
          m_tready <= 1'b0;
          repeat ($urandom_range(1, 5)) @(negedge clk);
        end
      end
    end
  end

  // Stimulus
  initial begin
    logic [7:0] lead;
    logic [7:0] b;
    logic       eob;
    int         seq_len;
    int         cut;
    int         kind;
    bit         broken;
    bit         hold_asked;
    bit         drained_mid;

    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tlast    = 1'b0;
    hold_req   = 1'b0;
    bytes_sent = 0;
    burst_left = 0;
    hold_asked  = 1'b0;
    drained_mid = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (opening_bytes[i]) send_byte(opening_bytes[i][7:0], opening_bytes[i][8]);
    wait_drained();

    while (bytes_sent < BYTE_TARGET) begin
      if (!hold_asked && bytes_sent >= 600) begin
        hold_asked = 1'b1;
        hold_req  <= 1'b1;
      end
      if (!drained_mid && bytes_sent >= 1200) begin
        drained_mid = 1'b1;
        wait_drained();
      end
      kind = $urandom_range(0, 9);
      if (kind < 8) begin
        // well-formed sequence with random payload, or a broken one, sometimes cut short
        broken  = (kind == 7);
        seq_len = $urandom_range(1, 6);
        lead    = 8'($urandom);
        case (seq_len)
          1: lead[7]   = 1'b0;
          2: lead[7:5] = 3'b110;
          3: lead[7:4] = 4'b1110;
          4: lead[7:3] = 5'b11110;
          5: lead[7:2] = 6'b111110;
          default: lead[7:1] = 7'b1111110;
        endcase
        cut = seq_len;
        if ($urandom_range(0, 7) == 0) cut = $urandom_range(1, seq_len);
        for (int k = 0; k < cut; k++) begin
          if (k == 0) begin
            b = lead;
          end else if (broken) begin
            b = 8'($urandom);
          end else begin
            b = {2'b10, 6'($urandom)};
          end
          eob = (k == cut - 1) && (cut < seq_len || $urandom_range(0, 4) == 0);
          send_byte(b, eob);
        end
      end else begin
        // noise
        send_byte(8'($urandom), $urandom_range(0, 3) == 0);
      end
    end

    wait_drained();
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
